// File: rtl/core/mbg_pkg.sv
`timescale 1ns / 1ps

package mbg_pkg;

    localparam int TABLE_WORDS = 624;
    localparam int POS_W       = $clog2(TABLE_WORDS);
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int TWIST_OFFSET = 397;

    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd3961;
    localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]  t_pos;

    // One step of the twist: upper bit of this word, lower bits of the next.
    function automatic t_word twist_word(input t_word upper, input t_word lower,
                                         input t_word far);
        t_word y;
        t_word r;
        y = (upper & HIGH_BIT) | (lower & LOW_BITS);
        r = far ^ (y >> 1);
        if (lower[0]) begin
            r = r ^ TWIST_MATRIX;
        end
        return r;
    endfunction

    function automatic t_word temper(input t_word x);
        t_word y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: rtl/core/mbg_ram.sv
`timescale 1ns / 1ps

module mbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mt19937_byte_generator_core.sv
`timescale 1ns / 1ps

// MT19937 byte generator.
// Input channel (i_valid, i_reseed, o_stall): each transfer requests one byte.
// With i_reseed high, or on the first request after reset, the state table is
// first refilled from the seed register, written through i_seed_we and
// i_seed_wdata; the user must write it only while the block is idle, as the
// block does not enforce this. A new seed waits for such a request.
// Output channel (o_valid, o_random_byte, i_stall): one transfer per request.
// A request loads the output register from ST_CALC once it is free; a seeding
// request first fills the table in ST_SEED, one word a cycle, paced by the
// seeding multiplier, then reads the first words back in ST_READ. The twist is
// done lazily, one word per request, using two copies of the table so that the
// next word and the word 397 ahead are read in the same cycle. No new request
// is taken until the last has loaded its byte. While the receiver stalls, the
// finished byte is held in the output register and the block still takes the
// next request, which waits in ST_CALC until the output register is free.
// Reset clears the control state and loads the seed register with 3961; the
// table contents are left as they are, since the first request reseeds.

module mt19937_byte_generator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [mbg_pkg::WORD_W-1:0]  i_seed_wdata,
    input  logic                        i_valid,
    input  logic                        i_reseed,
    output logic                        o_stall,
    output logic                        o_valid,
    output logic [mbg_pkg::BYTE_W-1:0]  o_random_byte,
    input  logic                        i_stall
);

    import mbg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEED = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_CALC = 2'd3;

    localparam t_pos LAST_POS  = t_pos'(TABLE_WORDS - 1);
    localparam t_pos FAR_SPLIT = t_pos'(TABLE_WORDS - TWIST_OFFSET);

    logic [1:0]         r_state, n_state;
    t_word              r_seed;
    t_word              r_seed_word, n_seed_word;
    t_pos               r_cnt, n_cnt;
    t_pos               r_pos, n_pos;
    t_word              r_upper, n_upper;
    logic               r_needs_init, n_needs_init;
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;

    logic  in_xfer;
    logic  out_free;
    logic  start_seed;
    t_pos  nxt_addr;
    t_pos  far_addr;
    logic  ram_re;
    logic  ram_we;
    t_pos  ram_waddr;
    t_word ram_wdata;
    t_word lower_word;
    t_word far_word;
    t_word new_word;
    t_word tempered_word;
    t_word seed_mixed;
    t_word seed_prod;

    assign in_xfer    = i_valid && !o_stall;
    assign out_free   = !r_out_valid || !i_stall;
    assign start_seed = i_reseed || r_needs_init;

    // Neighbours of the current position, wrapping round the table.
    assign nxt_addr = (r_pos == LAST_POS) ? '0 : r_pos + t_pos'(1);
    assign far_addr = (r_pos < FAR_SPLIT) ? r_pos + t_pos'(TWIST_OFFSET)
                                          : r_pos - FAR_SPLIT;

    assign ram_re = (r_state == ST_IDLE && in_xfer && !start_seed) || (r_state == ST_READ);
    assign ram_we = (r_state == ST_SEED) || (r_state == ST_CALC && out_free);
    assign ram_waddr = (r_state == ST_SEED) ? r_cnt : r_pos;
    assign ram_wdata = (r_state == ST_SEED) ? r_seed_word : new_word;

    // The word at the current position and every word after it still belong
    // to the previous generation, so the lazy twist sees exactly what a full
    // twist pass would see. The upper word is cached from the previous read.
    assign new_word      = twist_word(r_upper, lower_word, far_word);
    assign tempered_word = temper(new_word);

    // Seeding recurrence: one multiply per cycle into the seed word register.
    assign seed_mixed = r_seed_word ^ (r_seed_word >> 30);
    assign seed_prod  = seed_mixed * INIT_MULT;

    mbg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_WORDS)
    ) u_ram_next (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (nxt_addr),
        .o_rdata (lower_word)
    );

    mbg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_WORDS)
    ) u_ram_far (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (far_addr),
        .o_rdata (far_word)
    );

    always_comb begin
        n_state      = r_state;
        n_seed_word  = r_seed_word;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_upper      = r_upper;
        n_needs_init = r_needs_init;
        n_out_valid  = r_out_valid && i_stall;
        n_out_byte   = r_out_byte;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (start_seed) begin
                        n_state      = ST_SEED;
                        n_seed_word  = r_seed;
                        n_upper      = r_seed;
                        n_cnt        = '0;
                        n_needs_init = 1'b0;
                    end else begin
                        n_state = ST_CALC;
                    end
                end
            end
            ST_SEED: begin
                n_seed_word = seed_prod + t_word'(r_cnt) + t_word'(1);
                n_cnt       = r_cnt + t_pos'(1);
                if (r_cnt == LAST_POS) begin
                    n_state = ST_READ;
                    n_pos   = '0;
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_byte  = tempered_word[BYTE_W-1:0];
                    n_upper     = lower_word;
                    n_pos       = nxt_addr;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seed       <= SEED_RESET;
            r_pos        <= '0;
            r_cnt        <= '0;
            r_needs_init <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_cnt        <= n_cnt;
            r_needs_init <= n_needs_init;
            r_out_valid  <= n_out_valid;
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed_word <= n_seed_word;
        r_upper     <= n_upper;
        r_out_byte  <= n_out_byte;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_random_byte = r_out_byte;

`ifndef ASSERT_OFF
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < t_pos'(TABLE_WORDS))
        else $error("read position left the table");

    a_reseed_starts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && in_xfer && start_seed) |=> (r_state == ST_SEED && r_cnt == '0))
        else $error("seeding request did not start the table fill");

    a_fill_ends_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEED && r_cnt == LAST_POS) |=> (r_state == ST_READ && r_pos == '0))
        else $error("table fill did not restart the read position");

    a_calc_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && out_free) |=> (o_valid && r_state == ST_IDLE))
        else $error("finished word was not transferred to the output register");
`endif

endmodule

// File: tb/sv/mbg_byte_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the seed port of the byte generator, predicts
// every byte from its own copy of the generator state and compares the bytes
// that leave the block, in order, against those predictions.
module mbg_byte_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [mbg_pkg::WORD_W-1:0]  i_seed_wdata,
    input  logic                        i_req_valid,
    input  logic                        i_req_reseed,
    input  logic                        i_req_stall,
    input  logic                        i_res_valid,
    input  logic [mbg_pkg::BYTE_W-1:0]  i_res_byte,
    input  logic                        i_res_stall,
    output int                          o_fail_count,
    output int                          o_bytes_pending
);

    import mbg_pkg::*;

    localparam int REPORT_LIMIT = 10;

    t_word                  seed_reg;
    t_word                  mt_table [TABLE_WORDS];
    int unsigned            mt_pos;
    bit                     mt_unseeded;
    logic [BYTE_W-1:0]      bytes_due [$];
    int                     failures;

    function automatic void seed_table(input t_word start);
        t_word w;
        w = start;
        for (int k = 0; k < TABLE_WORDS; k++) begin
            mt_table[k] = w;
            w = INIT_MULT * (w ^ (w >> 30)) + t_word'(k + 1);
        end
    endfunction

    // Regenerates the whole table in place; words already rewritten are used
    // for the later ones, exactly as the standard generator does.
    function automatic void twist_table();
        t_word y;
        int    nxt;
        int    far;
        for (int k = 0; k < TABLE_WORDS; k++) begin
            nxt = (k + 1) % TABLE_WORDS;
            far = (k + TWIST_OFFSET) % TABLE_WORDS;
            y = {mt_table[k][WORD_W-1], mt_table[nxt][WORD_W-2:0]};
            mt_table[k] = mt_table[far] ^ {1'b0, y[WORD_W-1:1]}
                          ^ (mt_table[nxt][0] ? TWIST_MATRIX : t_word'(0));
        end
    endfunction

    function automatic t_word tempered(input t_word w);
        t_word y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    function automatic logic [BYTE_W-1:0] next_random_byte(input logic reseed);
        t_word w;
        if (reseed || mt_unseeded) begin
            seed_table(seed_reg);
            mt_unseeded = 1'b0;
            mt_pos = TABLE_WORDS;
        end
        if (mt_pos >= TABLE_WORDS) begin
            twist_table();
            mt_pos = 0;
        end
        w = tempered(mt_table[mt_pos]);
        mt_pos++;
        return w[BYTE_W-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [BYTE_W-1:0] want;
        if (!i_rst_n) begin
            seed_reg    = SEED_RESET;
            mt_pos      = TABLE_WORDS;
            mt_unseeded = 1'b1;
            failures    = 0;
            bytes_due.delete();
        end else begin
            if (i_seed_we) begin
                seed_reg = i_seed_wdata;
            end
            if (i_req_valid && !i_req_stall) begin
                bytes_due.push_back(next_random_byte(i_req_reseed));
            end
            if (i_res_valid && !i_res_stall) begin
                if (bytes_due.size() == 0) begin
                    if (failures < REPORT_LIMIT) begin
                        $display("%0t: byte 0x%02h transferred with none outstanding",
                                 $time, i_res_byte);
                    end
                    failures++;
                end else begin
                    want = bytes_due.pop_front();
                    if (want !== i_res_byte) begin
                        if (failures < REPORT_LIMIT) begin
                            $display("%0t: random_byte expected 0x%02h, got 0x%02h",
                                     $time, want, i_res_byte);
                        end
                        failures++;
                    end
                end
            end
        end
        o_bytes_pending <= bytes_due.size();
        o_fail_count    <= failures;
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Top level of the byte generator test. It only makes stimulus and gives the
// verdict; the checker beside the block predicts and compares every byte.
module testbench;

    import mbg_pkg::*;

    // How long a side waits before each transfer: drawn over the full range,
    // not at all, or only now and then.
    typedef enum int {IDLE_RANDOM, IDLE_NONE, IDLE_SPARSE} t_idle_mode;

    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 325;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    // A seeding request alone keeps both channels quiet while the table refills,
    // and each side may add its own drawn idle wait on top of that.
    localparam int WATCHDOG_LIMIT = 4000;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_seed_we    = 1'b0;
    logic [WORD_W-1:0]  i_seed_wdata = '0;
    logic               i_valid      = 1'b0;
    logic               i_reseed     = 1'b0;
    logic               i_stall      = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [BYTE_W-1:0]  o_random_byte;

    int                 fail_count;
    int                 bytes_pending;
    int                 quiet_cycles = 0;
    int unsigned        stall_left   = 0;
    t_idle_mode         tx_mode      = IDLE_RANDOM;
    t_idle_mode         rx_mode      = IDLE_RANDOM;

    mt19937_byte_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_wdata  (i_seed_wdata),
        .i_valid       (i_valid),
        .i_reseed      (i_reseed),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_random_byte (o_random_byte),
        .i_stall       (i_stall)
    );

    mbg_byte_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_seed_we       (i_seed_we),
        .i_seed_wdata    (i_seed_wdata),
        .i_req_valid     (i_valid),
        .i_req_reseed    (i_reseed),
        .i_req_stall     (o_stall),
        .i_res_valid     (o_valid),
        .i_res_byte      (o_random_byte),
        .i_res_stall     (i_stall),
        .o_fail_count    (fail_count),
        .o_bytes_pending (bytes_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            default:     return $urandom_range(0, 17);
        endcase
    endfunction

    // Receiver: after every output transfer it draws a number of cycles to
    // hold stall high. The count runs down whether or not a byte is waiting,
    // so the stall windows fall on every phase of the block's work.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                stall_left = draw_wait(rx_mode);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: counts cycles in which neither channel makes a transfer. The
    // short pauses around seed writes and at the end stay far below the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("mt19937_byte_generator_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request and returns at the edge where it is accepted. When no
    // gap is drawn, valid simply stays high and only the reseed flag moves on,
    // so valid is never lowered and raised again within one step.
    task automatic send_request(input logic reseed);
        int unsigned gap;
        gap = draw_wait(tx_mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_reseed <= reseed;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stops offering requests until every predicted byte has come out. The
    // first edge lets the checker count a request accepted at this very edge.
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
    endtask

    // The seed register is only written once the block is idle. Every request
    // gives exactly one byte, so an empty queue means the block has finished;
    // a few more cycles are allowed all the same.
    task automatic write_seed(input t_word value);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= value;
        @(posedge i_clk);
        i_seed_we    <= 1'b0;
    endtask

    initial begin
        logic rs;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first request after reset seeds from the reset value of the
        // seed register even though reseed is low; a reseed then restarts
        // the very same sequence.
        repeat (3) send_request(1'b0);
        send_request(1'b1);

        // A seed written without reseed must not disturb the running
        // sequence until a reseeding request picks it up.
        write_seed('0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        write_seed('1);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        write_seed(32'h8000_0000);
        send_request(1'b1);
        send_request(1'b0);

        write_seed(32'h0000_0001);
        send_request(1'b1);
        send_request(1'b1);

        // Random phases. The first two never reseed, so the read position
        // runs past the end of the table and a second twist is exercised;
        // the second one also starts with a seed write that stays unused.
        // Later phases reseed now and then and often right after a new seed.
        for (int p = 0; p < PHASES; p++) begin
            tx_mode = t_idle_mode'(p % 3);
            rx_mode = (p == 4) ? IDLE_NONE : t_idle_mode'((p + 1) % 3);
            if (p > 0) begin
                write_seed((p == 3) ? '1 : (p == 5) ? '0 : t_word'($urandom()));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    wait_until_drained();
                end
                if (p < 2) begin
                    rs = 1'b0;
                end else if (n == 0) begin
                    rs = 1'($urandom_range(0, 1));
                end else begin
                    rs = ($urandom_range(0, 199) == 0);
                end
                send_request(rs);
            end
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("mt19937_byte_generator_core test passed");
        end else begin
            $display("mt19937_byte_generator_core test failed");
        end
        $finish;
    end

endmodule
